// File: hdl/vpa_pkg.sv
// Package for the variable partition allocator: widths, modes, status codes
// and controller state type. No dependencies.
`default_nettype none
package vpa_pkg;
  localparam int MEMORY_UNITS_DEF = 128;
  localparam int MAX_SEGMENTS_DEF = 16;

  typedef enum logic [2:0] {
    MODE_FIRST   = 3'd0,
    MODE_BEST    = 3'd1,
    MODE_WORST   = 3'd2,
    MODE_FREE    = 3'd3,
    MODE_COMPACT = 3'd4,
    MODE_DEFRAG  = 3'd5,
    MODE_FULL    = 3'd6,
    MODE_RESET   = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_FIT   = 3'd1,
    ST_NO_SEG   = 3'd2,
    ST_ALR_FREE = 3'd3,
    ST_FULL     = 3'd4,
    ST_BAD_SIZE = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SPLIT, S_FREE, S_DCHK, S_DPASS, S_DCOPY,
    S_CPASS, S_CCOPY, S_INIT, S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request, clear per-request state
    logic scan_step;  // examine one entry for allocation
    logic split;      // commit allocation (split/mark)
    logic free_op;    // do the free check/commit
    logic dchk_step;  // look for any used entry
    logic dpass_step; // one defrag gather step
    logic dcopy;      // copy defrag buffer back
    logic cpass_step; // one compact step
    logic ccopy;      // copy compact buffer back
    logic init;       // reset table
    logic idx_clr;    // clear scan index
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_end;   // index reached end of pass
    logic fit_hit;    // first-fit found at current entry
    logic any_used;
    logic pass_one;   // defrag is in its second pass
  } stat_t;
endpackage
`default_nettype wire

// File: hdl/vpa_datapath.sv
// Segment table, scan index, shared defrag/compact buffer, result register.
// Depends on vpa_pkg.
`default_nettype none
module vpa_datapath #(
  parameter int MEMORY_UNITS = vpa_pkg::MEMORY_UNITS_DEF,
  parameter int MAX_SEGMENTS = vpa_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire vpa_pkg::cmd_t  cmd,
  output vpa_pkg::stat_t      st,
  input  wire logic [2:0]     in_mode,
  input  wire logic [7:0]     in_request_size,
  input  wire logic [4:0]     in_segment_number,
  output logic [2:0]          res_status,
  output logic [6:0]          res_alloc_address,
  output logic [4:0]          res_node_index,
  output logic [4:0]          res_segment_count
);
  localparam int AW = $clog2(MEMORY_UNITS + 1);
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int RW = (AW > 8) ? AW : 8;

  logic [AW-1:0] addr_r [MAX_SEGMENTS];
  logic [AW-1:0] size_r [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] used_r;
  logic [CW-1:0] count_r;
  logic [AW-1:0] baddr_r [MAX_SEGMENTS];
  logic [AW-1:0] bsize_r [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] bused_r;
  logic [CW-1:0] w_r, idx_r;
  logic [AW-1:0] next_r;
  logic pass_r, found_r, any_r;
  logic [IW-1:0] pick_r;
  logic [2:0] mode_r;
  logic [RW-1:0] req_r;
  logic [4:0] node_r;
  logic [2:0] status_r;
  logic [6:0] aaddr_r;
  logic [4:0] nidx_r;

  logic [IW-1:0] ci;
  logic [AW-1:0] csz;
  logic cu, cand;
  assign ci   = idx_r[IW-1:0];
  assign csz  = size_r[ci];
  assign cu   = used_r[ci];
  assign cand = !cu && (RW'(csz) >= req_r) && (req_r != '0);

  assign st.scan_end = (idx_r >= count_r);
  assign st.fit_hit  = cand && (mode_r == vpa_pkg::MODE_FIRST);
  assign st.any_used = any_r;
  assign st.pass_one = pass_r;

  logic [IW-1:0] wm1;
  assign wm1 = IW'(w_r - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      count_r  <= CW'(1);
      addr_r[0] <= '0;
      size_r[0] <= AW'(MEMORY_UNITS);
    end else if (cmd.init) begin
      used_r   <= '0;
      count_r  <= CW'(1);
      addr_r[0] <= '0;
      size_r[0] <= AW'(MEMORY_UNITS);
      status_r <= vpa_pkg::ST_OK;
      aaddr_r <= '0;
      nidx_r <= '0;
    end else begin
      if (cmd.load) begin
        mode_r <= in_mode;
        req_r  <= RW'(in_request_size);
        node_r <= in_segment_number;
        found_r <= 1'b0;
        any_r  <= 1'b0;
        pass_r <= 1'b0;
        w_r    <= '0;
        next_r <= '0;
        status_r <= vpa_pkg::ST_OK;
        aaddr_r <= '0;
        nidx_r <= '0;
      end
      if (cmd.idx_clr) idx_r <= '0;
      if (cmd.scan_step) begin
        if (cand) begin
          if (!found_r ||
              (mode_r == vpa_pkg::MODE_BEST && csz < size_r[pick_r]) ||
              (mode_r == vpa_pkg::MODE_WORST && csz > size_r[pick_r])) begin
            pick_r <= ci;
          end
          found_r <= 1'b1;
        end
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.split) begin
        if (req_r == '0) status_r <= vpa_pkg::ST_BAD_SIZE;
        else if (!found_r) status_r <= vpa_pkg::ST_NO_FIT;
        else if (RW'(size_r[pick_r]) > req_r && count_r >= CW'(MAX_SEGMENTS))
          status_r <= vpa_pkg::ST_FULL;
        else begin
          if (RW'(size_r[pick_r]) > req_r) begin
            // shift entries above pick up by one
            for (int i = 1; i < MAX_SEGMENTS; i++) begin
              if (IW'(i) > pick_r + 1'b1 && CW'(i) <= count_r) begin
                addr_r[i] <= addr_r[i-1];
                size_r[i] <= size_r[i-1];
                used_r[i] <= used_r[i-1];
              end else if (IW'(i) == pick_r + 1'b1) begin
                addr_r[i] <= AW'(RW'(addr_r[pick_r]) + req_r);
                size_r[i] <= AW'(RW'(size_r[pick_r]) - req_r);
                used_r[i] <= 1'b0;
              end
            end
            size_r[pick_r] <= AW'(req_r);
            count_r <= count_r + 1'b1;
          end
          used_r[pick_r] <= 1'b1;
          aaddr_r <= 7'(addr_r[pick_r]);
          nidx_r  <= 5'(pick_r) + 5'd1;
        end
      end
      if (cmd.free_op) begin
        if (node_r == '0 || CW'(node_r) > count_r || 32'(node_r) > MAX_SEGMENTS)
          status_r <= vpa_pkg::ST_NO_SEG;
        else if (!used_r[IW'(node_r - 1'b1)]) status_r <= vpa_pkg::ST_ALR_FREE;
        else begin
          used_r[IW'(node_r - 1'b1)] <= 1'b0;
          nidx_r <= node_r;
        end
      end
      if (cmd.dchk_step) begin
        if (cu) any_r <= 1'b1;
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.dpass_step) begin
        if (idx_r >= count_r) begin
          pass_r <= 1'b1;
          idx_r <= '0;
        end else begin
          if (cu != pass_r) begin
            bsize_r[w_r[IW-1:0]] <= csz;
            bused_r[w_r[IW-1:0]] <= cu;
            baddr_r[w_r[IW-1:0]] <= next_r;
            next_r <= next_r + csz;
            w_r <= w_r + 1'b1;
          end
          idx_r <= idx_r + 1'b1;
        end
      end
      if (cmd.cpass_step) begin
        if (w_r != '0 && !cu && !bused_r[wm1])
          bsize_r[wm1] <= bsize_r[wm1] + csz;
        else begin
          baddr_r[w_r[IW-1:0]] <= addr_r[ci];
          bsize_r[w_r[IW-1:0]] <= csz;
          bused_r[w_r[IW-1:0]] <= cu;
          w_r <= w_r + 1'b1;
        end
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.dcopy || cmd.ccopy) begin
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
          if (CW'(i) < w_r) begin
            addr_r[i] <= baddr_r[i];
            size_r[i] <= bsize_r[i];
            used_r[i] <= bused_r[i];
          end
        end
        if (cmd.ccopy) count_r <= w_r;
        w_r <= '0;
      end
    end
  end

  assign res_status = status_r;
  assign res_alloc_address = aaddr_r;
  assign res_node_index = nidx_r;
  assign res_segment_count = 5'(count_r);
endmodule
`default_nettype wire

// File: hdl/vpa_ctrl.sv
// Controller state machine sequencing scan, split, free, reset, defrag and compact steps.
// Depends on vpa_pkg.
`default_nettype none
module vpa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [2:0]     in_mode,
  output logic                out_valid,
  input  wire logic           out_ready,
  output vpa_pkg::cmd_t       cmd,
  input  wire vpa_pkg::stat_t st
);
  vpa_pkg::state_t state_r, state_nxt;
  logic full_r, full_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vpa_pkg::S_IDLE;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      full_r  <= full_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    full_nxt  = full_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      vpa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.idx_clr = 1'b1;
          full_nxt = (in_mode == vpa_pkg::MODE_FULL);
          case (in_mode) inside
            vpa_pkg::MODE_FIRST, vpa_pkg::MODE_BEST, vpa_pkg::MODE_WORST:
              state_nxt = vpa_pkg::S_SCAN;
            vpa_pkg::MODE_FREE:    state_nxt = vpa_pkg::S_FREE;
            vpa_pkg::MODE_COMPACT: state_nxt = vpa_pkg::S_CPASS;
            vpa_pkg::MODE_DEFRAG, vpa_pkg::MODE_FULL: state_nxt = vpa_pkg::S_DCHK;
            default: state_nxt = vpa_pkg::S_INIT;
          endcase
        end
      end
      vpa_pkg::S_SCAN: begin
        if (st.scan_end) state_nxt = vpa_pkg::S_SPLIT;
        else begin
          cmd.scan_step = 1'b1;
          if (st.fit_hit) state_nxt = vpa_pkg::S_SPLIT;
        end
      end
      vpa_pkg::S_SPLIT: begin cmd.split = 1'b1; state_nxt = vpa_pkg::S_DONE; end
      vpa_pkg::S_FREE:  begin cmd.free_op = 1'b1; state_nxt = vpa_pkg::S_DONE; end
      vpa_pkg::S_INIT:  begin cmd.init = 1'b1; state_nxt = vpa_pkg::S_DONE; end
      vpa_pkg::S_DCHK: begin
        if (st.scan_end) begin
          cmd.idx_clr = 1'b1;
          if (st.any_used) state_nxt = vpa_pkg::S_DPASS;
          else if (full_r) state_nxt = vpa_pkg::S_CPASS;
          else state_nxt = vpa_pkg::S_DONE;
        end else cmd.dchk_step = 1'b1;
      end
      vpa_pkg::S_DPASS: begin
        cmd.dpass_step = 1'b1;
        if (st.scan_end && st.pass_one) state_nxt = vpa_pkg::S_DCOPY;
      end
      vpa_pkg::S_DCOPY: begin
        cmd.dcopy = 1'b1;
        cmd.idx_clr = 1'b1;
        state_nxt = full_r ? vpa_pkg::S_CPASS : vpa_pkg::S_DONE;
      end
      vpa_pkg::S_CPASS: begin
        if (st.scan_end) state_nxt = vpa_pkg::S_CCOPY;
        else cmd.cpass_step = 1'b1;
      end
      vpa_pkg::S_CCOPY: begin cmd.ccopy = 1'b1; state_nxt = vpa_pkg::S_DONE; end
      vpa_pkg::S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = vpa_pkg::S_IDLE;
      end
      default: state_nxt = vpa_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: hdl/variable_partition_allocator_top.sv
// Variable partition allocator (first/best/worst fit, free, compact, defrag).
// Usage: present mode, request_size and segment_number with in_valid; the
// block takes one request at a time (in_ready is high only while idle). Each
// request yields exactly one result on out_* with out_valid, held until out_ready.
// An allocate scans the table one entry per cycle (first fit stops on the first
// hit; a miss or a zero size, and best or worst fit, scan the whole table),
// then splits and marks; free and reset update the table directly; compact
// makes one pass over the table and copies its buffer back; defrag first checks
// for a used segment and, if there is one, gathers the used segments, then the
// free ones, and copies them back; full defrag then adds its compact pass.
// A new request is taken only in the idle state, after the previous result has
// been handed over.
// Reset (rst_n low, synchronous) leaves one free segment spanning the whole
// memory and segment_count 1. A stalled receiver holds the result and the
// block takes no new request until it is taken.
// Depends on vpa_pkg, vpa_ctrl, vpa_datapath.
`default_nettype none
module variable_partition_allocator_top #(
  parameter int MEMORY_UNITS = vpa_pkg::MEMORY_UNITS_DEF,
  parameter int MAX_SEGMENTS = vpa_pkg::MAX_SEGMENTS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_mode,
  input  wire logic [7:0] in_request_size,
  input  wire logic [4:0] in_segment_number,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_status,
  output logic [6:0]      out_alloc_address,
  output logic [4:0]      out_node_index,
  output logic [4:0]      out_segment_count
);
  vpa_pkg::cmd_t  cmd;
  vpa_pkg::stat_t st;

  vpa_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_mode,
    .out_valid, .out_ready, .cmd, .st
  );

  vpa_datapath #(.MEMORY_UNITS(MEMORY_UNITS), .MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
    .clk, .rst_n, .cmd, .st, .in_mode, .in_request_size, .in_segment_number,
    .res_status(out_status), .res_alloc_address(out_alloc_address),
    .res_node_index(out_node_index), .res_segment_count(out_segment_count)
  );
endmodule
`default_nettype wire

// File: hdl/vpa_checker.sv
// Port-level checker for the allocator top level, with its bind.
// Depends on variable_partition_allocator_top ports only.
`default_nettype none
module vpa_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_status,
  input wire logic [6:0] out_alloc_address,
  input wire logic [4:0] out_node_index,
  input wire logic [4:0] out_segment_count
);
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("accept while result pending");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_segment_count != 5'd0) else $error("zero segment count");
  a_fail_no_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != 3'd0 |-> out_node_index == 5'd0 &&
    out_alloc_address == 7'd0) else $error("failed request reports position");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped");
endmodule

bind variable_partition_allocator_top vpa_checker u_vpa_checker (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready,
  .out_status, .out_alloc_address, .out_node_index, .out_segment_count
);
`default_nettype wire
